FILE: src/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on every clock
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

FILE: src/tbdp_pkg.sv
// ----------------------------------------------------------------------------
// tbdp_pkg
// Types and constants of the tournament branch direction predictor.
// ----------------------------------------------------------------------------
package tbdp_pkg;
	localparam int BIMODAL_ENTRIES = 1024;
	localparam int CHOICE_ENTRIES = 1024;
	localparam int PATTERN_COLUMNS = 1024;
	localparam int HISTORY_BITS = 8;
	localparam int MAX_LOOKAHEAD = 8;
	localparam int BI_W = $clog2(BIMODAL_ENTRIES);
	localparam int CI_W = $clog2(CHOICE_ENTRIES);
	localparam int COL_W = $clog2(PATTERN_COLUMNS);
	localparam int PAT_W = COL_W + HISTORY_BITS;
	localparam int PAT_DEPTH = 1 << PAT_W;
	localparam int MAXD = (BIMODAL_ENTRIES > CHOICE_ENTRIES) ?
		((BIMODAL_ENTRIES > PAT_DEPTH) ? BIMODAL_ENTRIES : PAT_DEPTH) :
		((CHOICE_ENTRIES > PAT_DEPTH) ? CHOICE_ENTRIES : PAT_DEPTH);
	localparam int CLR_W = $clog2(MAXD) + 1;
	localparam int IN_W = 88;
	localparam int OUT_W = 24;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_MULTI = 2'd2;
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	localparam logic [2:0] MODE_PERFECT = 3'd0;
	localparam logic [2:0] MODE_TAKEN = 3'd1;
	localparam logic [2:0] MODE_NOT_TAKEN = 3'd2;
	localparam logic [2:0] MODE_BIMODAL = 3'd3;
	localparam logic [2:0] MODE_TWO_LEVEL = 3'd4;
	localparam logic [2:0] MODE_COMBINED = 3'd5;

	localparam logic [1:0] CTR_INIT = 2'd2;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_READ = 6'b000100,
		ST_EVAL = 6'b001000,
		ST_WALK = 6'b010000,
		ST_OUT = 6'b100000
	} state_t;

	function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic up);
		logic [1:0] r;
		if (up) r = (c == 2'd3) ? 2'd3 : c + 2'd1;
		else r = (c == 2'd0) ? 2'd0 : c - 2'd1;
		return r;
	endfunction
endpackage

FILE: src/tournament_branch_direction_predictor_unit.sv
// ----------------------------------------------------------------------------
// tournament_branch_direction_predictor_unit
// Bimodal / two-level tournament predictor with a multi-step pattern walk.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its three counter memories to weakly taken,
// one entry a cycle over the pattern table depth (262144 entries), and takes
// no transaction until done. A lookup then passes through accept, memory
// read, evaluate and output, an update through accept, memory read, and
// evaluate and write; a multiple lookup in two-level mode adds a walk and
// an evaluate step for each further speculated direction. The output state
// holds while m_tready is low. The unit takes a new transaction only after
// it has finished the last one.
// s_tdata, from bit 0: command[1:0], pc[33:2], next_pc[65:34],
// instr_size[69:66], is_unconditional[70], is_internal[71],
// lookahead_count[75:72], history_snapshot[83:76], bimodal_guess_in[84],
// two_level_guess_in[85], chose_two_level_in[86].
`include "assert_macros.svh"
module tournament_branch_direction_predictor_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [2:0] cfg_wr_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [tbdp_pkg::IN_W-1:0] s_tdata,   // fields as listed above
	output logic m_tvalid,
	input logic m_tready,
	// predict_taken, bimodal_guess, two_level_guess, chose_two_level,
	// history_row[7:0], prediction_mask[7:0], mode_error, zero pad
	output logic [tbdp_pkg::OUT_W-1:0] m_tdata
);
	import tbdp_pkg::*;

	state_t state_q;
	logic [2:0] mode_q;
	logic [CLR_W-1:0] clr_q;
	logic [IN_W-1:0] item_q;
	logic [HISTORY_BITS-1:0] hist_q, row_q, start_q;
	logic [3:0] step_q, n_q;
	logic [7:0] mask_q;
	logic [OUT_W-1:0] out_q;

	logic [1:0] bim_mem [BIMODAL_ENTRIES];
	logic [1:0] cho_mem [CHOICE_ENTRIES];
	logic [1:0] pat_mem [PAT_DEPTH];
	logic [1:0] bim_rd_q, cho_rd_q, pat_rd_q;

	logic [1:0] cmd;
	logic [31:0] pc, npc;
	logic [3:0] isz, cnt;
	logic uncond, intern, bim_in, two_in, chose_in, taken;
	logic [HISTORY_BITS-1:0] snap;
	assign cmd = item_q[1:0];
	assign pc = item_q[33:2];
	assign npc = item_q[65:34];
	assign isz = item_q[69:66];
	assign uncond = item_q[70];
	assign intern = item_q[71];
	assign cnt = item_q[75:72];
	assign snap = item_q[76 +: HISTORY_BITS];
	assign bim_in = item_q[84];
	assign two_in = item_q[85];
	assign chose_in = item_q[86];
	assign taken = npc != (pc + {28'd0, isz});

	logic [BI_W-1:0] bi;
	logic [CI_W-1:0] ci;
	logic [COL_W-1:0] col;
	assign bi = pc[BI_W-1:0];
	assign ci = pc[CI_W-1:0];
	assign col = pc[COL_W-1:0];

	// pattern read address: walk row during lookahead, snapshot on update
	logic [HISTORY_BITS-1:0] rd_row;
	logic [PAT_W-1:0] pat_ra;
	always_comb begin
		if (state_q == ST_READ && cmd == CMD_UPDATE) rd_row = snap;
		else rd_row = row_q;
		pat_ra = {rd_row, col};
	end

	logic bim_we, cho_we, pat_we;
	logic [BI_W-1:0] bim_wa;
	logic [CI_W-1:0] cho_wa;
	logic [PAT_W-1:0] pat_wa;
	logic [1:0] bim_wd, cho_wd, pat_wd;
	logic upd_ok;
	assign upd_ok = !uncond && !intern &&
		(mode_q == MODE_BIMODAL || mode_q == MODE_TWO_LEVEL || mode_q == MODE_COMBINED);
	always_comb begin
		bim_we = 1'b0; cho_we = 1'b0; pat_we = 1'b0;
		bim_wa = bi; cho_wa = ci; pat_wa = {snap, col};
		bim_wd = ctr_train(bim_rd_q, taken);
		cho_wd = ctr_train(cho_rd_q, two_in == taken);
		pat_wd = ctr_train(pat_rd_q, taken);
		if (state_q == ST_CLEAR) begin
			bim_we = clr_q < CLR_W'(BIMODAL_ENTRIES);
			cho_we = clr_q < CLR_W'(CHOICE_ENTRIES);
			pat_we = 1'b1;
			bim_wa = clr_q[BI_W-1:0]; cho_wa = clr_q[CI_W-1:0];
			pat_wa = clr_q[PAT_W-1:0];
			bim_wd = CTR_INIT; cho_wd = CTR_INIT; pat_wd = CTR_INIT;
		end else if (state_q == ST_EVAL && cmd == CMD_UPDATE && upd_ok) begin
			bim_we = mode_q == MODE_BIMODAL || (mode_q == MODE_COMBINED && !chose_in);
			pat_we = mode_q == MODE_TWO_LEVEL || (mode_q == MODE_COMBINED && chose_in);
			cho_we = mode_q == MODE_COMBINED && bim_in != two_in;
		end
	end

	always_ff @(posedge clk) begin
		if (bim_we) bim_mem[bim_wa] <= bim_wd;
		if (cho_we) cho_mem[cho_wa] <= cho_wd;
		if (pat_we) pat_mem[pat_wa] <= pat_wd;
		bim_rd_q <= bim_mem[bi];
		cho_rd_q <= cho_mem[ci];
		pat_rd_q <= pat_mem[pat_ra];
	end

	logic [3:0] n_eff;
	assign n_eff = (cnt == 4'd0) ? 4'd1 :
		(cnt > 4'(MAX_LOOKAHEAD)) ? 4'(MAX_LOOKAHEAD) : cnt;

	logic bg, tg, ch, pred;
	always_comb begin
		bg = bim_rd_q > 2'd1;
		tg = pat_rd_q > 2'd1;
		ch = cho_rd_q > 2'd1;
		pred = 1'b0;
		unique case (mode_q)
			MODE_PERFECT: pred = taken;
			MODE_TAKEN: pred = 1'b1;
			MODE_BIMODAL: pred = bg;
			MODE_TWO_LEVEL: pred = tg;
			MODE_COMBINED: pred = ch ? tg : bg;
			default: pred = 1'b0;
		endcase
	end

	logic [HISTORY_BITS-1:0] next_row;
	assign next_row = {row_q[HISTORY_BITS-2:0], pat_rd_q > 2'd1};

	logic [OUT_W-1:0] out_d;
	always_comb begin
		out_d = '0;
		if (cmd == CMD_LOOKUP) begin
			if (uncond || intern) out_d[0] = 1'b1;
			else begin
				out_d[0] = pred;
				out_d[1] = (mode_q == MODE_BIMODAL || mode_q == MODE_COMBINED) & bg;
				out_d[2] = (mode_q == MODE_TWO_LEVEL || mode_q == MODE_COMBINED) & tg;
				out_d[3] = (mode_q == MODE_COMBINED) & ch;
				out_d[11:4] = (mode_q == MODE_TWO_LEVEL || mode_q == MODE_COMBINED) ?
					8'(start_q) : 8'd0;
			end
		end else if (mode_q != MODE_TWO_LEVEL) begin
			out_d[20] = 1'b1;
		end else begin
			out_d[0] = (step_q == 4'd0) ? tg : mask_q[0];
			out_d[2] = (step_q == 4'd0) ? tg : mask_q[0];
			out_d[11:4] = 8'(start_q);
			out_d[19:12] = mask_q | ({7'd0, tg} << step_q[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mode_q <= MODE_TWO_LEVEL;
			clr_q <= '0;
			hist_q <= '0;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(MAXD - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) state_q <= ST_READ;
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (cmd == CMD_UPDATE || cmd == CMD_IGNORED) begin
						if (cmd == CMD_UPDATE && upd_ok &&
							(mode_q == MODE_TWO_LEVEL ||
							(mode_q == MODE_COMBINED && chose_in)))
							hist_q <= {hist_q[HISTORY_BITS-2:0], taken};
						state_q <= ST_IDLE;
					end else if (cmd == CMD_MULTI && mode_q == MODE_TWO_LEVEL &&
						step_q + 4'd1 < n_q) begin
						state_q <= ST_WALK;
					end else state_q <= ST_OUT;
				end
				ST_WALK: state_q <= ST_EVAL;
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) item_q <= s_tdata;
		if (state_q == ST_READ) begin
			start_q <= hist_q;
			step_q <= 4'd0;
			mask_q <= 8'd0;
			n_q <= n_eff;
		end
		if (state_q == ST_IDLE) row_q <= hist_q;
		if (state_q == ST_EVAL) begin
			mask_q[step_q[2:0]] <= tg;
			if (cmd == CMD_MULTI) begin
				step_q <= step_q + 4'd1;
				row_q <= next_row;
			end
			out_q <= out_d;
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_OUT;
	assign m_tdata = out_q;

	`ASSERT_IMPLIES(a_one_side, clk, arst_n, m_tvalid, !s_tready)
	`ASSERT_NEXT(a_accept_read, clk, arst_n, s_tvalid && s_tready, state_q == ST_READ)
	`ASSERT_IMPLIES(a_err_mask, clk, arst_n, m_tvalid && m_tdata[20], m_tdata[19:0] == 20'd0)
endmodule

FILE: bench/tournament_branch_direction_predictor_unit_tb.sv
// ----------------------------------------------------------------------------
// tournament_branch_direction_predictor_unit_tb
// Drives lookups, updates and multiple lookups through the stream ports in
// every predictor mode, tracks the counter tables alongside the unit and
// compares each result transaction with the expected one.
// ----------------------------------------------------------------------------
module tournament_branch_direction_predictor_unit_tb;
	import tbdp_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000000;

	typedef struct packed {
		logic       chose_in;
		logic       two_in;
		logic       bim_in;
		logic [7:0] snap;
		logic [3:0] count;
		logic       internal;
		logic       uncond;
		logic [3:0] size;
		logic [31:0] npc;
		logic [31:0] pc;
		logic [1:0] cmd;
	} branch_req_t;

	typedef struct packed {
		logic       mode_error;
		logic [7:0] mask;
		logic [7:0] row;
		logic       chose;
		logic       two;
		logic       bim;
		logic       taken;
	} branch_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [2:0] cfg_wr_data = MODE_TWO_LEVEL;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;  // command, pc, next_pc, instr_size, flags, count, snapshot, guesses
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;      // taken, bimodal, two-level, chose, row, mask, mode_error

	tournament_branch_direction_predictor_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	logic [1:0] bim_ctr [BIMODAL_ENTRIES];
	logic [1:0] choice_ctr [CHOICE_ENTRIES];
	logic [1:0] pat_ctr [PAT_DEPTH];
	logic [7:0] hist;
	logic [2:0] mode;

	branch_req_t pending_reqs[$];
	branch_resp_t expected_resps[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int gap = 0;
	int stall = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
		if (up) return (c == 2'd3) ? c : c + 2'd1;
		return (c == 2'd0) ? c : c - 2'd1;
	endfunction

	function automatic int pat_addr(input logic [7:0] row, input logic [31:0] pc);
		return {row, pc[COL_W-1:0]};
	endfunction

	task automatic predict_branch(input branch_req_t q);
		branch_resp_t e;
		logic outcome;
		logic [7:0] row;
		logic t;
		int n;
		e = '0;
		outcome = q.npc != q.pc + 32'(q.size);
		case (q.cmd)
			CMD_LOOKUP: begin
				if (q.uncond || q.internal) begin
					e.taken = 1'b1;
				end else begin
					if (mode == MODE_PERFECT) e.taken = outcome;
					if (mode == MODE_TAKEN) e.taken = 1'b1;
					if (mode == MODE_BIMODAL || mode == MODE_COMBINED) begin
						e.bim = bim_ctr[q.pc[BI_W-1:0]] > 1;
						e.taken = e.bim;
					end
					if (mode == MODE_TWO_LEVEL || mode == MODE_COMBINED) begin
						e.row = hist;
						e.two = pat_ctr[pat_addr(hist, q.pc)] > 1;
						e.taken = e.two;
					end
					if (mode == MODE_COMBINED) begin
						e.chose = choice_ctr[q.pc[CI_W-1:0]] > 1;
						e.taken = e.chose ? e.two : e.bim;
					end
				end
				expected_resps.push_back(e);
			end
			CMD_UPDATE: begin
				if (!(q.uncond || q.internal) && mode >= MODE_BIMODAL
						&& mode <= MODE_COMBINED) begin
					if (mode == MODE_BIMODAL || (mode == MODE_COMBINED && !q.chose_in))
						bim_ctr[q.pc[BI_W-1:0]] = bump(bim_ctr[q.pc[BI_W-1:0]], outcome);
					if (mode == MODE_TWO_LEVEL || (mode == MODE_COMBINED && q.chose_in)) begin
						pat_ctr[pat_addr(q.snap, q.pc)] =
							bump(pat_ctr[pat_addr(q.snap, q.pc)], outcome);
						hist = {hist[6:0], outcome};
					end
					if (mode == MODE_COMBINED && q.bim_in != q.two_in)
						choice_ctr[q.pc[CI_W-1:0]] =
							bump(choice_ctr[q.pc[CI_W-1:0]], q.two_in == outcome);
				end
			end
			CMD_MULTI: begin
				if (mode != MODE_TWO_LEVEL) begin
					e.mode_error = 1'b1;
				end else begin
					n = (q.count == 0) ? 1 : q.count;
					if (n > MAX_LOOKAHEAD) n = MAX_LOOKAHEAD;
					row = hist;
					t = pat_ctr[pat_addr(row, q.pc)] > 1;
					e.mask[0] = t;
					for (int i = 1; i < n; i++) begin
						row = {row[6:0], t};
						t = pat_ctr[pat_addr(row, q.pc)] > 1;
						e.mask[i] = t;
					end
					e.row = hist;
					e.taken = e.mask[0];
					e.two = e.mask[0];
				end
				expected_resps.push_back(e);
			end
			default: ;
		endcase
	endtask

	function automatic branch_req_t rand_req(input logic [1:0] cmd, input logic [31:0] pc,
			input logic flags_on);
		branch_req_t q;
		q.cmd = cmd;
		q.pc = pc;
		q.size = $urandom_range(0, 15);
		q.npc = ($urandom_range(0, 1)) ? pc + 32'(q.size) : $urandom;
		q.uncond = flags_on && ($urandom_range(0, 9) == 0);
		q.internal = flags_on && ($urandom_range(0, 9) == 0);
		q.count = $urandom_range(0, 15);
		q.snap = (cmd == CMD_UPDATE && $urandom_range(0, 3) != 0) ? hist : 8'($urandom);
		q.bim_in = $urandom_range(0, 1);
		q.two_in = $urandom_range(0, 1);
		q.chose_in = $urandom_range(0, 1);
		return q;
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_branch(branch_req_t'(s_tdata[86:0]));
		end
		if (s_tvalid && !s_tready) begin
		end else if (gap > 0) begin
			gap <= gap - 1;
			s_tvalid <= 1'b0;
		end else if (pending_reqs.size() > 0 && arst_n && !cfg_wr_en) begin
			s_tdata <= IN_W'(pending_reqs.pop_front());
			s_tvalid <= 1'b1;
			gap <= pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_resps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				branch_resp_t e, a;
				e = expected_resps.pop_front();
				a = branch_resp_t'(m_tdata[20:0]);
				if (a !== e || m_tdata[OUT_W-1:21] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", e, m_tdata);
				end
			end
		end
		if (stall > 0) begin
			stall <= stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) stall <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic wait_drain();
		while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_mode(input logic [2:0] m);
		wait_drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode = m;
	endtask

	initial begin
		branch_req_t q;
		logic [31:0] pc;
		logic [2:0] modes[$];
		for (int i = 0; i < BIMODAL_ENTRIES; i++) bim_ctr[i] = CTR_INIT;
		for (int i = 0; i < CHOICE_ENTRIES; i++) choice_ctr[i] = CTR_INIT;
		for (int i = 0; i < PAT_DEPTH; i++) pat_ctr[i] = CTR_INIT;
		hist = '0;
		mode = MODE_TWO_LEVEL;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);

		// extremes in reset mode
		q = '0;
		q.cmd = CMD_LOOKUP; pending_reqs.push_back(q);
		q.pc = '1; q.npc = '1; q.size = 4'hf; pending_reqs.push_back(q);
		q.uncond = 1; pending_reqs.push_back(q);
		q.uncond = 0; q.internal = 1; pending_reqs.push_back(q);
		q = '0; q.cmd = CMD_MULTI; q.count = 0; pending_reqs.push_back(q);
		q.count = 4'hf; q.pc = '1; pending_reqs.push_back(q);
		q = '0; q.cmd = CMD_UPDATE; q.npc = 32'h100; q.snap = 8'hff;
		q.bim_in = 1; q.chose_in = 1; pending_reqs.push_back(q);
		q.uncond = 1; pending_reqs.push_back(q);
		q = '0; q.cmd = CMD_IGNORED; q.pc = 32'hffff_ffff; pending_reqs.push_back(q);
		q.cmd = CMD_MULTI; q.count = 8; pending_reqs.push_back(q);
		for (int m = 0; m < 8; m++) begin
			set_mode(3'(m));
			q = '0; q.cmd = CMD_LOOKUP; q.pc = 32'h40; q.npc = 32'h80;
			pending_reqs.push_back(q);
			q.cmd = CMD_UPDATE; q.two_in = 1; q.chose_in = 1; pending_reqs.push_back(q);
			q.cmd = CMD_MULTI; q.count = 3; pending_reqs.push_back(q);
		end

		modes = '{MODE_TWO_LEVEL, MODE_COMBINED, MODE_BIMODAL, 3'd7, MODE_TWO_LEVEL,
			MODE_PERFECT, MODE_COMBINED, MODE_TAKEN, MODE_NOT_TAKEN, MODE_TWO_LEVEL};
		foreach (modes[k]) begin
			set_mode(modes[k]);
			for (int i = 0; i < 160; i++) begin
				pc = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 15) * 4);
				case ($urandom_range(0, 9)) inside
					[0:3]: q = rand_req(CMD_LOOKUP, pc, 1);
					[4:7]: q = rand_req(CMD_UPDATE, pc, 1);
					8: q = rand_req(CMD_MULTI, pc, 0);
					default: q = rand_req(2'($urandom_range(0, 3)), pc, 1);
				endcase
				pending_reqs.push_back(q);
				// predictor state is read at acceptance, so keep queue shallow
				while (pending_reqs.size() > 2) @(posedge clk);
			end
		end
		wait_drain();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+src
src/tbdp_pkg.sv
src/tournament_branch_direction_predictor_unit.sv
bench/tournament_branch_direction_predictor_unit_tb.sv
